// ===== hdl/gbns_pkg.sv =====
package gbns_pkg;

  // Operation codes carried on the input tuser.
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_ACK      = 3'd1;
  localparam logic [2:0] OP_END_SEEN = 3'd2;
  localparam logic [2:0] OP_FOREIGN  = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;

  // Result kinds carried on the output tuser.
  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_END   = 3'd1;
  localparam logic [2:0] KIND_DENY  = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_ABORT = 3'd4;

  // Packet payload size and the cap on results per item.
  localparam int unsigned PAYLOAD_SIZE = 958;
  localparam int unsigned RESULT_CAP   = 63;

  // Result of the shared divider.
  typedef struct packed {
    logic        done;
    logic [22:0] quotient;
    logic [9:0]  remainder;
  } div_res_t;

endpackage

// ===== hdl/go_back_n_sender_core.sv =====
// Go-Back-N sender controller with 8-bit sequence numbers. The block takes one item at a
// time and is ready only while it stands idle. An item on an idle transfer that is not a
// start returns to idle after its handle step with no result; any other item passes the
// handle, check and plan steps, then gives its results, one per cycle while the sink takes
// them, each result waiting in the output register until the sink takes it (up to 63
// results for one item). A start with a non-zero length and data also runs the shared
// divider, which splits the length into 958-byte packets with a reciprocal product and a
// remainder step. Registers are written and read over the APB port at byte addresses 0, 4 and 8.
module go_back_n_sender_core
  import gbns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // message_bytes[31:0], no_data[32], ack_number[40:33]
  input  logic [2:0]  s_tuser,  // operation[2:0]
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // sequence_res[7:0], packet_index[30:8], payload_bytes[40:31]
  output logic [2:0]  m_tuser,  // kind[2:0]
  output logic        m_tlast,
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HANDLE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_PLAN   = 3'd4;
  localparam logic [2:0] S_SEND   = 3'd5;

  localparam logic [2:0] M_NONE  = 3'd0;
  localparam logic [2:0] M_DATA  = 3'd1;
  localparam logic [2:0] M_END   = 3'd2;
  localparam logic [2:0] M_DONE  = 3'd3;
  localparam logic [2:0] M_ABORT = 3'd4;

  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_RETX    = 2'd1;
  localparam logic [1:0] REG_CONNECT = 2'd2;

  logic [2:0]  state;
  logic [2:0]  mode;
  logic        deny_pend;
  logic [5:0]  n_cnt;

  logic [2:0]  op_r;
  logic [31:0] bytes_r;
  logic        nodata_r;
  logic [7:0]  ack_r;

  logic        active;
  logic [7:0]  window_base;
  logic [5:0]  send_offset;
  logic [22:0] packets_done;
  logic [22:0] final_index;
  logic [9:0]  final_bytes;
  logic        end_only;
  logic [15:0] retransmit_count;
  logic [31:0] connection_count;

  logic [5:0]  window_size;
  logic [15:0] retransmit_ticks;
  logic [31:0] connection_ticks;

  logic        ovalid;
  logic [2:0]  okind;
  logic [7:0]  oseq;
  logic [22:0] oidx;
  logic [9:0]  obytes;
  logic        olast;

  logic        accept;
  logic        cfg_write;
  logic        div_start;
  div_res_t    div_res;

  logic [7:0]  adv;
  logic        adv_ok;
  logic [5:0]  offset_after_ack;
  logic [22:0] idx;
  logic [22:0] total;
  logic        can_send;
  logic        more_after;
  logic        out_free;
  logic        load;
  logic [2:0]  load_kind;
  logic [7:0]  load_seq;
  logic [22:0] load_idx;
  logic [9:0]  load_bytes;
  logic        load_last;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Configuration registers; a window of zero is taken as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size      <= 6'd1;
      retransmit_ticks <= 16'd100;
      connection_ticks <= 32'd1000;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_WINDOW:  window_size <= (pwdata[5:0] == 6'd0) ? 6'd1 : pwdata[5:0];
        REG_RETX:    retransmit_ticks <= pwdata[15:0];
        REG_CONNECT: connection_ticks <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_WINDOW:  prdata = {26'd0, window_size};
      REG_RETX:    prdata = {16'd0, retransmit_ticks};
      REG_CONNECT: prdata = connection_ticks;
      default:     prdata = 32'd0;
    endcase
  end

  // Input item capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= s_tuser;
      bytes_r  <= s_tdata[31:0];
      nodata_r <= s_tdata[32];
      ack_r    <= s_tdata[40:33];
    end
  end

  // The length split runs on the shared divider.
  assign div_start = (state == S_HANDLE) && !active && (op_r == OP_START) &&
                     !nodata_r && (bytes_r != 32'd0);

  gbns_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bytes_r - 32'd1),
    .res      (div_res)
  );

  // ACK advance, taken modulo 256 and accepted when 1 to 127 ahead of the base.
  always_comb begin
    adv    = ack_r - window_base;
    adv_ok = (adv != 8'd0) && !adv[7];
    offset_after_ack = ({2'd0, send_offset} > adv) ? (send_offset - adv[5:0]) : 6'd0;
  end

  // Window position of the next data send and whether further sends follow it.
  always_comb begin
    idx        = packets_done + {17'd0, send_offset};
    total      = end_only ? 23'd0 : (final_index + 23'd1);
    can_send   = (send_offset < window_size) && (idx <= final_index);
    more_after = (({1'b0, send_offset} + 7'd1) < {1'b0, window_size}) &&
                 ((n_cnt + 6'd1) < 6'(RESULT_CAP)) && (idx < final_index);
  end

  assign out_free = !ovalid || m_tready;
  assign load     = (state == S_SEND) && out_free;

  // The result that the send step places in the output register.
  always_comb begin
    load_kind  = KIND_DENY;
    load_seq   = 8'd0;
    load_idx   = 23'd0;
    load_bytes = 10'd0;
    load_last  = 1'b1;
    if (deny_pend) begin
      load_last = (mode == M_NONE);
    end else begin
      case (mode)
        M_DATA: begin
          load_kind  = KIND_DATA;
          load_seq   = window_base + {2'd0, send_offset};
          load_idx   = idx;
          load_bytes = (idx == final_index) ? final_bytes : 10'(PAYLOAD_SIZE);
          load_last  = !more_after;
        end
        M_END: begin
          load_kind = KIND_END;
          load_seq  = window_base;
        end
        M_DONE:  load_kind = KIND_DONE;
        M_ABORT: load_kind = KIND_ABORT;
        default: ;
      endcase
    end
  end

  // Sequencer and transfer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      mode             <= M_NONE;
      deny_pend        <= 1'b0;
      n_cnt            <= 6'd0;
      active           <= 1'b0;
      window_base      <= 8'd0;
      send_offset      <= 6'd0;
      packets_done     <= 23'd0;
      final_index      <= 23'd0;
      final_bytes      <= 10'd0;
      end_only         <= 1'b0;
      retransmit_count <= 16'd0;
      connection_count <= 32'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) state <= S_HANDLE;
        end
        S_HANDLE: begin
          // A foreign packet on an active transfer owes a deny reply first.
          deny_pend <= active && (op_r == OP_FOREIGN);
          if (!active) begin
            if (op_r == OP_START) begin
              active           <= 1'b1;
              window_base      <= 8'd0;
              send_offset      <= 6'd0;
              packets_done     <= 23'd0;
              retransmit_count <= 16'd0;
              connection_count <= 32'd0;
              end_only         <= nodata_r;
              if (nodata_r || (bytes_r == 32'd0)) begin
                final_index <= 23'd0;
                final_bytes <= 10'd0;
                state       <= S_CHECK;
              end else begin
                state <= S_DIV;
              end
            end else begin
              state <= S_IDLE;
            end
          end else begin
            case (op_r)
              OP_ACK: begin
                connection_count <= 32'd0;
                if (adv_ok) begin
                  retransmit_count <= 16'd0;
                  packets_done     <= packets_done + {15'd0, adv};
                  window_base      <= ack_r;
                  send_offset      <= offset_after_ack;
                end
              end
              OP_END_SEEN: connection_count <= 32'd0;
              OP_TICK: begin
                if (retransmit_count != 16'hFFFF)
                  retransmit_count <= retransmit_count + 16'd1;
                if (connection_count != 32'hFFFF_FFFF)
                  connection_count <= connection_count + 32'd1;
              end
              default: ;
            endcase
            state <= S_CHECK;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            final_index <= div_res.quotient;
            final_bytes <= div_res.remainder + 10'd1;
            state       <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Retransmit timeout rewinds the window.
          if (retransmit_count >= retransmit_ticks) begin
            retransmit_count <= 16'd0;
            send_offset      <= 6'd0;
          end
          state <= S_PLAN;
        end
        S_PLAN: begin
          n_cnt <= deny_pend ? 6'd1 : 6'd0;
          if (connection_count >= connection_ticks) begin
            mode  <= M_ABORT;
            state <= S_SEND;
          end else if (packets_done < total) begin
            if (can_send) begin
              mode  <= M_DATA;
              state <= S_SEND;
            end else begin
              mode  <= M_NONE;
              state <= deny_pend ? S_SEND : S_IDLE;
            end
          end else if (packets_done == total) begin
            if (send_offset != window_size) begin
              mode  <= M_END;
              state <= S_SEND;
            end else begin
              mode  <= M_NONE;
              state <= deny_pend ? S_SEND : S_IDLE;
            end
          end else begin
            mode  <= M_DONE;
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_free) begin
            if (deny_pend) begin
              deny_pend <= 1'b0;
              if (mode == M_NONE) state <= S_IDLE;
            end else begin
              case (mode)
                M_DATA: begin
                  send_offset <= send_offset + 6'd1;
                  n_cnt       <= n_cnt + 6'd1;
                  if (!more_after) state <= S_IDLE;
                end
                M_END: begin
                  send_offset <= window_size;
                  state       <= S_IDLE;
                end
                M_DONE, M_ABORT: begin
                  active <= 1'b0;
                  state  <= S_IDLE;
                end
                default: state <= S_IDLE;
              endcase
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register parting the sequencer from the sink.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      okind  <= load_kind;
      oseq   <= load_seq;
      oidx   <= load_idx;
      obytes <= load_bytes;
      olast  <= load_last;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = {7'd0, obytes, oidx, oseq};
  assign m_tuser  = okind;
  assign m_tlast  = olast;

  // An accepted item always starts its handling in the next cycle.
  a_accept_handle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_HANDLE))
    else $error("accepted item not handled");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

  // A data send never goes beyond the result cap of one item.
  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    (load && !deny_pend && (mode == M_DATA)) |-> (n_cnt < 6'(RESULT_CAP)))
    else $error("result cap exceeded");

  // The final result of an item returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && load_last) |=> (state == S_IDLE))
    else $error("sequencer busy after final result");

endmodule

// ===== hdl/gbns_div.sv =====
module gbns_div
  import gbns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  output div_res_t    res
);

  // 958 is 2 * 479, so the halved dividend is scaled by 2^40 / 479, rounded up.
  // The rounding error stays small enough to be exact for any 31-bit value.
  localparam logic [31:0] RECIP = 32'h88D1_80CE;

  logic        quo_step;
  logic        rem_step;
  logic        done;
  logic [31:0] num_r;
  logic [22:0] quo_r;
  logic [9:0]  rem_r;
  logic [22:0] quo_next;
  logic [9:0]  back;

  // The quotient comes from one reciprocal product; the remainder is below 958,
  // so the low ten bits of the dividend less the quotient times 958 give it.
  always_comb begin
    quo_next = 23'((63'(num_r[31:1]) * 63'(RECIP)) >> 40);
    back     = 10'(quo_r[9:0] * 10'(PAYLOAD_SIZE));
  end

  // Step control: load, quotient, remainder, then a single done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      quo_step <= 1'b0;
      rem_step <= 1'b0;
      done     <= 1'b0;
    end else begin
      quo_step <= start;
      rem_step <= quo_step;
      done     <= rem_step;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    if (start) num_r <= dividend;
    if (quo_step) quo_r <= quo_next;
    if (rem_step) rem_r <= num_r[9:0] - back;
  end

  assign res.done      = done;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule
